### rtl/ewrm_pkg.sv
// package: widths, payload types, register codes and sequencer states for the rpm meter
`timescale 1ns / 1ps

package ewrm_pkg;

    // field widths
    localparam int TimeW    = 16;
    localparam int CountW   = 16;
    localparam int CntBits  = 16;            // encoder counter width used for differences
    localparam int PeriodW  = 16;
    localparam int PprW     = 12;
    localparam int GearW    = 8;
    localparam int RpmW     = 32;
    localparam int CfgDataW = 16;

    // microseconds per minute
    localparam int UsMinW = 26;
    localparam logic [UsMinW-1:0] UsPerMinute = 26'd60000000;

    // datapath widths
    localparam int RateW   = CntBits + UsMinW;   // dc * 60e6
    localparam int NumW    = RateW + GearW;      // rate * ratio numerator
    localparam int DenW    = PprW + TimeW;       // pulses_per_rev * dt
    localparam int DivCntW = $clog2(NumW);

    // register reset values
    localparam logic [PeriodW-1:0] PeriodReset = 16'd2000;
    localparam logic [PprW-1:0]    PprReset    = 12'd600;
    localparam logic [GearW-1:0]   EncGearReset   = 8'd9;
    localparam logic [GearW-1:0]   WheelGearReset = 8'd108;

    typedef enum logic [1:0] {
        CFG_SAMPLE_PERIOD = 2'd0,
        CFG_PULSES_PER_REV = 2'd1,
        CFG_ENCODER_GEAR = 2'd2,
        CFG_WHEEL_GEAR = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [TimeW-1:0]  now_us;
        logic [CountW-1:0] enc_count;
    } in_item_t;

    typedef struct packed {
        logic [RpmW-1:0] wheel_rpm;
        logic            sampled;
    } out_item_t;

    typedef struct packed {
        logic [PeriodW-1:0] sample_period_us;
        logic [PprW-1:0]    pulses_per_rev;
        logic [GearW-1:0]   ratio_num;
        logic [GearW-1:0]   ratio_den;
    } cfg_regs_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LAUNCH1,
        ST_WAIT1,
        ST_SCALE,
        ST_LAUNCH2,
        ST_WAIT2,
        ST_DONE
    } state_t;

endpackage

### rtl/ewrm_cfg.sv
// configuration register file of the rpm meter
`timescale 1ns / 1ps

module ewrm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  ewrm_pkg::cfg_index_t           cfg_index,
    input  logic [ewrm_pkg::CfgDataW-1:0]  cfg_data,
    output ewrm_pkg::cfg_regs_t            regs
);
    import ewrm_pkg::*;

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    // register decode
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_PERIOD:  regs_next.sample_period_us = cfg_data[PeriodW-1:0];
                CFG_PULSES_PER_REV: regs_next.pulses_per_rev   = cfg_data[PprW-1:0];
                CFG_ENCODER_GEAR:   regs_next.ratio_num        = cfg_data[GearW-1:0];
                CFG_WHEEL_GEAR:     regs_next.ratio_den        = cfg_data[GearW-1:0];
                default:            regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.sample_period_us <= PeriodReset;
            regs_reg.pulses_per_rev   <= PprReset;
            regs_reg.ratio_num        <= EncGearReset;
            regs_reg.ratio_den        <= WheelGearReset;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

### rtl/ewrm_snap.sv
// snapshot store: sample timer, two time/count snapshots and their differences
`timescale 1ns / 1ps

module ewrm_snap (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  ewrm_pkg::in_item_t            item,
    input  logic [ewrm_pkg::PeriodW-1:0]  period,
    output logic                          take,
    output logic [ewrm_pkg::TimeW-1:0]    dt,
    output logic [ewrm_pkg::CntBits-1:0]  dc
);
    import ewrm_pkg::*;

    logic [TimeW-1:0]   last_time_reg,   last_time_next;
    logic [TimeW-1:0]   newest_time_reg, newest_time_next;
    logic [TimeW-1:0]   older_time_reg,  older_time_next;
    logic [CntBits-1:0] newest_cnt_reg,  newest_cnt_next;
    logic [CntBits-1:0] older_cnt_reg,   older_cnt_next;
    logic [TimeW-1:0]   elapsed;

    // sample timer compare, wraps modulo 2^16
    assign elapsed = item.now_us - last_time_reg;
    assign take    = (elapsed >= period);

    // shift newest snapshot to older on a taken sample
    always_comb
    begin
        last_time_next   = last_time_reg;
        newest_time_next = newest_time_reg;
        older_time_next  = older_time_reg;
        newest_cnt_next  = newest_cnt_reg;
        older_cnt_next   = older_cnt_reg;
        if (accept && take)
        begin
            last_time_next   = item.now_us;
            older_time_next  = newest_time_reg;
            older_cnt_next   = newest_cnt_reg;
            newest_time_next = item.now_us;
            newest_cnt_next  = item.enc_count[CntBits-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg   <= '0;
            newest_time_reg <= '0;
            older_time_reg  <= '0;
            newest_cnt_reg  <= '0;
            older_cnt_reg   <= '0;
        end
        else
        begin
            last_time_reg   <= last_time_next;
            newest_time_reg <= newest_time_next;
            older_time_reg  <= older_time_next;
            newest_cnt_reg  <= newest_cnt_next;
            older_cnt_reg   <= older_cnt_next;
        end
    end

    // wrap-safe differences
    assign dt = newest_time_reg - older_time_reg;
    assign dc = newest_cnt_reg - older_cnt_reg;

endmodule

### rtl/ewrm_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ewrm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ewrm_pkg::NumW-1:0]   num,
    input  logic [ewrm_pkg::DenW-1:0]   den,
    output logic                        done,
    output logic [ewrm_pkg::NumW-1:0]   quo
);
    import ewrm_pkg::*;

    logic [NumW-1:0]    quo_reg, quo_next;
    logic [DenW-1:0]    rem_reg, rem_next;
    logic [DenW-1:0]    den_reg, den_next;
    logic [DivCntW-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DenW:0]      trial;
    logic [DenW:0]      diff;
    logic               fits;

    // one trial subtraction per cycle
    assign trial = {rem_reg, quo_reg[NumW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DenW-1:0] : trial[DenW-1:0];
            quo_next = {quo_reg[NumW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DivCntW'(NumW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // shift registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### rtl/encoder_wheel_rpm_meter_core.sv
// top level of the encoder wheel rpm meter
`timescale 1ns / 1ps

// Wheel rpm meter, counts-per-window method. Each poll transaction carries a
// microsecond timestamp and an encoder count; when the sample period has passed
// the snapshots advance, and every poll returns one result with the wheel rpm
// (saturated at 32 bits, 0 when the time difference or pulses_per_rev is zero)
// and a flag telling whether a snapshot was taken. One poll is handled at a
// time: after acceptance the sequencer forms the products and runs two passes
// through one bit-serial divider of 50 steps each, skipping both when the
// first divisor is zero. The next poll is taken while the finished result still
// waits in the output register. Configuration writes are always ready and must
// only be issued while no poll is in flight.
module encoder_wheel_rpm_meter_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  ewrm_pkg::in_item_t            in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output ewrm_pkg::out_item_t           out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  ewrm_pkg::cfg_index_t          cfg_index,
    input  logic [ewrm_pkg::CfgDataW-1:0] cfg_data
);
    import ewrm_pkg::*;

    cfg_regs_t        regs;
    logic             accept;
    logic             take;
    logic [TimeW-1:0] dt;
    logic [CntBits-1:0] dc;
    logic             div_start;
    logic             div_done;
    logic [NumW-1:0]  div_quo;

    state_t           state_reg, state_next;
    logic [NumW-1:0]  num_reg, num_next;
    logic [DenW-1:0]  den_reg, den_next;
    logic [RpmW-1:0]  rpm_reg, rpm_next;
    logic             sampled_reg, sampled_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;
    logic [GearW-1:0] wheel_div;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign wheel_div = (regs.ratio_den == '0) ? GearW'(1) : regs.ratio_den;

    ewrm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (regs)
    );

    ewrm_snap u_snap (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .period (regs.sample_period_us),
        .take   (take),
        .dt     (dt),
        .dc     (dc)
    );

    ewrm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // sequencer: products, first division, gear scaling, second division, output load
    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        rpm_next       = rpm_reg;
        sampled_next   = sampled_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    sampled_next = take;
                    state_next   = ST_PREP;
                end
            end
            ST_PREP:
            begin
                num_next   = NumW'(RateW'(dc) * RateW'(UsPerMinute));
                den_next   = DenW'(regs.pulses_per_rev) * DenW'(dt);
                state_next = ST_LAUNCH1;
            end
            ST_LAUNCH1:
            begin
                if (den_reg == '0)
                begin
                    rpm_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT1;
                end
            end
            ST_WAIT1:
            begin
                if (div_done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                num_next   = NumW'(div_quo[RateW-1:0]) * NumW'(regs.ratio_num);
                den_next   = DenW'(wheel_div);
                state_next = ST_LAUNCH2;
            end
            ST_LAUNCH2:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT2;
            end
            ST_WAIT2:
            begin
                if (div_done)
                begin
                    rpm_next   = (|div_quo[NumW-1:RpmW]) ? '1 : div_quo[RpmW-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // load the output register once it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.wheel_rpm = rpm_reg;
                    out_data_next.sampled   = sampled_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        den_reg      <= den_next;
        rpm_reg      <= rpm_next;
        sampled_reg  <= sampled_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### rtl/ewrm_checker.sv
// port-level checker for the rpm meter and its bind
`timescale 1ns / 1ps

module ewrm_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input ewrm_pkg::out_item_t  out_data
);
    import ewrm_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // a result leaves only through a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped without transaction");

    // one poll at a time: the input stalls right after a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall)
        else $error("poll accepted while another is in flight");

    // no result appears the cycle after a poll is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind encoder_wheel_rpm_meter_core ewrm_checker u_ewrm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

### tb/ewrm_rpm_checker.sv
// checker for the rpm meter: watches all channels, predicts each poll result and compares
`timescale 1ns / 1ps

module ewrm_rpm_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  ewrm_pkg::in_item_t            in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  ewrm_pkg::out_item_t           out_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  ewrm_pkg::cfg_index_t          cfg_index,
    input  logic [ewrm_pkg::CfgDataW-1:0] cfg_data,
    output int                            fail_count,
    output int                            rpm_pending
);

    import ewrm_pkg::*;

    // shadow copy of the configuration registers
    logic [PeriodW-1:0] period_us;
    logic [PprW-1:0]    ppr;
    logic [GearW-1:0]   enc_gear;
    logic [GearW-1:0]   whl_gear;

    // shadow copy of the snapshot state
    logic [TimeW-1:0]   last_snap_us;
    logic [TimeW-1:0]   snap_new_us;
    logic [TimeW-1:0]   snap_old_us;
    logic [CntBits-1:0] snap_new_cnt;
    logic [CntBits-1:0] snap_old_cnt;

    // results still owed by the block, oldest first
    out_item_t rpm_due_q[$];

    // advance the snapshots for one poll and work out its wheel rpm
    function automatic out_item_t rpm_for_poll(in_item_t poll);
        logic [TimeW-1:0]   elapsed;
        logic [TimeW-1:0]   dt;
        logic [CntBits-1:0] dc;
        logic [63:0]        span;
        logic [63:0]        rate;
        logic [63:0]        scaled;
        logic [63:0]        divisor;
        out_item_t          res;
        elapsed = poll.now_us - last_snap_us;
        res.sampled = (elapsed >= period_us);
        if (res.sampled)
        begin
            last_snap_us = poll.now_us;
            snap_old_us  = snap_new_us;
            snap_old_cnt = snap_new_cnt;
            snap_new_us  = poll.now_us;
            snap_new_cnt = poll.enc_count[CntBits-1:0];
        end
        dt = snap_new_us - snap_old_us;
        dc = snap_new_cnt - snap_old_cnt;
        span = 64'(ppr) * 64'(dt);
        if (span == 64'd0)
        begin
            res.wheel_rpm = '0;
        end
        else
        begin
            rate = (64'(dc) * 64'(UsPerMinute)) / span;
            if (rate > (64'd1 << 56))
                rate = 64'd1 << 56;
            // a zero wheel gear acts as a ratio of one
            divisor = (whl_gear == '0) ? 64'd1 : 64'(whl_gear);
            scaled = (rate * 64'(enc_gear)) / divisor;
            if (scaled > 64'hFFFF_FFFF)
                scaled = 64'hFFFF_FFFF;
            res.wheel_rpm = scaled[RpmW-1:0];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t due;
        out_item_t got;
        if (!rst_n)
        begin
            period_us    = PeriodReset;
            ppr          = PprReset;
            enc_gear     = EncGearReset;
            whl_gear     = WheelGearReset;
            last_snap_us = '0;
            snap_new_us  = '0;
            snap_old_us  = '0;
            snap_new_cnt = '0;
            snap_old_cnt = '0;
            rpm_due_q.delete();
            fail_count   = 0;
            rpm_pending  = 0;
        end
        else
        begin
            // register write transaction
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SAMPLE_PERIOD:  period_us = cfg_data[PeriodW-1:0];
                    CFG_PULSES_PER_REV: ppr       = cfg_data[PprW-1:0];
                    CFG_ENCODER_GEAR:   enc_gear  = cfg_data[GearW-1:0];
                    CFG_WHEEL_GEAR:     whl_gear  = cfg_data[GearW-1:0];
                    default: ;
                endcase
            end

            // result transaction against the oldest expectation
            if (out_valid && !out_stall)
            begin
                got = out_data;
                if (rpm_due_q.size() == 0)
                begin
                    $error("result with no poll pending: wheel_rpm %0d sampled %0b",
                           got.wheel_rpm, got.sampled);
                    fail_count++;
                end
                else
                begin
                    due = rpm_due_q.pop_front();
                    if (got.wheel_rpm !== due.wheel_rpm)
                    begin
                        $error("wheel_rpm: expected %0d, got %0d", due.wheel_rpm, got.wheel_rpm);
                        fail_count++;
                    end
                    if (got.sampled !== due.sampled)
                    begin
                        $error("sampled: expected %0b, got %0b", due.sampled, got.sampled);
                        fail_count++;
                    end
                end
            end

            // poll transaction
            if (in_valid && !in_stall)
                rpm_due_q.push_back(rpm_for_poll(in_data));

            rpm_pending = rpm_due_q.size();
        end
    end

endmodule

### tb/tb_encoder_wheel_rpm_meter_core.sv
// testbench top for the rpm meter: clock, reset, poll and register stimulus, verdict
`timescale 1ns / 1ps

module tb_encoder_wheel_rpm_meter_core;

    import ewrm_pkg::*;

    localparam int WatchdogLimit = 5000;
    localparam int SettleCycles  = 150;
    localparam int PhaseCount    = 8;
    localparam int PhaseItems    = 180;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid;
    logic                in_stall;
    in_item_t            in_data;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_item_t           out_data;
    logic                cfg_valid;
    logic                cfg_ready;
    cfg_index_t          cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    int fail_count;
    int rpm_pending;

    // idling bounds and poll generator state
    int               gap_max = 9;
    int               stall_max = 9;
    int               stall_left = 0;
    int               period_cur = 2000;
    int               idle_cycles = 0;
    logic [TimeW-1:0]  t_now = '0;
    logic [CountW-1:0] t_cnt = '0;

    encoder_wheel_rpm_meter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ewrm_rpm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .rpm_pending (rpm_pending)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // result side: random stall per result, drawn when the previous one goes through
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (out_valid && stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (out_valid)
                stall_left = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WatchdogLimit)
                begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // one poll transaction; valid stays high on return
    task automatic send_poll(input logic [TimeW-1:0] now_v, input logic [CountW-1:0] cnt_v);
        int gap;
        gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data.now_us    <= now_v;
        in_data.enc_count <= cnt_v;
        in_valid          <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // stop polling and wait for every owed result
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (rpm_pending != 0) @(negedge clk);
    endtask

    // one register write transaction; valid stays high on return
    task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // write all four registers, junk in the unused upper data bits
    task automatic set_meter(input int period, input int pulses, input int eg, input int wg);
        write_reg(CFG_SAMPLE_PERIOD, 16'(period));
        write_reg(CFG_PULSES_PER_REV, {4'($urandom), 12'(pulses)});
        write_reg(CFG_ENCODER_GEAR, {8'($urandom), 8'(eg)});
        write_reg(CFG_WHEEL_GEAR, {8'($urandom), 8'(wg)});
        cfg_valid  <= 1'b0;
        period_cur = period;
    endtask

    // mostly polls near the sample period with plausible counts, some short steps and noise
    task automatic next_poll();
        int pick;
        int step;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            step = period_cur + $urandom_range(0, period_cur / 8 + 3);
            if (step > 65535)
                step = 65535;
        end
        else if (pick < 9)
        begin
            step = (period_cur > 0) ? $urandom_range(0, period_cur - 1) : 0;
        end
        else
        begin
            step = $urandom_range(0, 65535);
        end
        t_now = t_now + 16'(step);
        pick = $urandom_range(0, 9);
        if (pick < 5)
            t_cnt = t_cnt + 16'($urandom_range(0, 3000));
        else if (pick < 8)
            t_cnt = 16'($urandom);
        else
            t_cnt = t_cnt - 16'($urandom_range(1, 400));
    endtask

    initial
    begin
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SAMPLE_PERIOD;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: first sample, steady speed, count wrap, time wrap
        send_poll(16'd0, 16'd0);
        send_poll(16'd1999, 16'd5);
        send_poll(16'd2000, 16'd600);
        send_poll(16'd4000, 16'd1200);
        send_poll(16'd6000, 16'd1100);
        send_poll(16'hFFFF, 16'hFFFF);
        send_poll(16'd1500, 16'd10);
        send_poll(16'd2000, 16'h0010);

        // every poll samples, zero time difference, saturation, zero wheel gear
        drain();
        set_meter(0, 1, 255, 0);
        send_poll(16'd2000, 16'h0010);
        send_poll(16'd2001, 16'hFFFF);
        send_poll(16'd2002, 16'hFFFF);

        // longest period, zero pulses per rev, zero encoder gear
        drain();
        set_meter(65535, 0, 0, 255);
        send_poll(16'd2001, 16'h1234);
        send_poll(16'h8000, 16'h8000);

        // shortest period, largest pulses per rev
        drain();
        set_meter(1, 4095, 1, 255);
        send_poll(16'd2002, 16'h0000);
        send_poll(16'd2002, 16'hAAAA);
        send_poll(16'h5555, 16'h5555);
        send_poll(16'hAAAA, 16'hAAAA);

        // random phases, each under its own settings
        for (int p = 0; p < PhaseCount; p++)
        begin
            drain();
            case (p)
                0: set_meter(2000, 600, 9, 108);
                1: set_meter(1, 1, 255, 1);
                2: set_meter(65535, 4095, 1, 255);
                3: set_meter(0, $urandom_range(1, 4095), $urandom_range(1, 255), 0);
                4: set_meter($urandom_range(1, 5000), 0, $urandom_range(0, 255),
                             $urandom_range(0, 255));
                5: set_meter($urandom_range(1, 5000), $urandom_range(1, 4095), 0,
                             $urandom_range(1, 255));
                default: set_meter($urandom_range(1, 3000), $urandom_range(1, 4095),
                                   $urandom_range(1, 255), $urandom_range(1, 255));
            endcase
            // some phases run without any idling
            gap_max   = (p % 3 == 1) ? 0 : 9;
            stall_max = (p % 3 == 1) ? 0 : 9;
            for (int i = 0; i < PhaseItems; i++)
            begin
                if (i == PhaseItems / 2)
                    drain();
                next_poll();
                send_poll(t_now, t_cnt);
            end
        end

        drain();
        repeat (SettleCycles) @(posedge clk);
        if (fail_count == 0 && rpm_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
